// ----- rtl/serial_frame_receiver_top_macros.svh -----
// Assertion macros shared by the serial frame receiver RTL.
// Depends on nothing; define SYNTH to compile the checks out.
`ifndef SERIAL_FRAME_RECEIVER_TOP_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_TOP_MACROS_SVH
`ifndef SYNTH
`define SFR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SFR_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFR_ASSERT(lbl, clk, rst, prop, msg)
`define SFR_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/sfr_pkg.sv -----
// Types and constants of the serial frame receiver.
// Used by every module of the block; depends on nothing.
package sfr_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_SYNC    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_VERSION = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LEN = 2'd2;

  localparam logic [7:0]  SYNC_RESET    = 8'hFF;
  localparam logic [7:0]  VERSION_RESET = 8'hFE;
  localparam logic [15:0] MAX_LEN_RESET = 16'd512;

  localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
  localparam logic [2:0] KIND_GOOD     = 3'd1;
  localparam logic [2:0] KIND_LEN_BAD  = 3'd2;
  localparam logic [2:0] KIND_TOO_LONG = 3'd3;
  localparam logic [2:0] KIND_DATA_BAD = 3'd4;

  typedef enum logic [8:0] {
    PH_HUNT      = 9'b000000001,
    PH_VERSION   = 9'b000000010,
    PH_LEN_LO    = 9'b000000100,
    PH_LEN_HI    = 9'b000001000,
    PH_LEN_CSUM  = 9'b000010000,
    PH_TOPIC_LO  = 9'b000100000,
    PH_TOPIC_HI  = 9'b001000000,
    PH_PAYLOAD   = 9'b010000000,
    PH_DATA_CSUM = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [7:0]  sync_byte;
    logic [7:0]  version_byte;
    logic [15:0] max_payload_length;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] msg_topic;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [15:0] payload_length;
  } result_t;

endpackage

// ----- rtl/serial_frame_receiver_top.sv -----
// Serial frame receiver: one received byte per beat in, payload bytes and frame status out.
// Results are registered: in the result register, or in its skid entry while output stalls.
// Throughput: one byte per cycle; rx_stall rises only when the result register and its
// skid entry are both occupied. Synchronous active-high reset returns to the sync hunt
// and loads the register defaults (sync 0xFF, version 0xFE, max length 512).
module serial_frame_receiver_top import sfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         kind,
  output logic [15:0]        msg_topic,
  output logic [7:0]         payload_byte,
  output logic [15:0]        byte_index,
  output logic [15:0]        payload_length,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t    cfg;
  logic    accept;
  logic    res_valid;
  result_t res;
  logic    full;
  result_t out_data;

  assign rx_stall = full;
  assign accept   = rx_valid && !rx_stall;

  sfr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfr_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  sfr_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign kind           = out_data.kind;
  assign msg_topic      = out_data.msg_topic;
  assign payload_byte   = out_data.payload_byte;
  assign byte_index     = out_data.byte_index;
  assign payload_length = out_data.payload_length;

endmodule

// ----- rtl/sfr_cfg.sv -----
// Configuration registers of the serial frame receiver.
// Depends on sfr_pkg for the register indexes and reset values.
module sfr_cfg import sfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [15:0]        cfg_data,
  output cfg_t               cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_byte          <= SYNC_RESET;
      cfg.version_byte       <= VERSION_RESET;
      cfg.max_payload_length <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SYNC:    cfg.sync_byte          <= cfg_data[7:0];
        CFG_VERSION: cfg.version_byte       <= cfg_data[7:0];
        CFG_MAX_LEN: cfg.max_payload_length <= cfg_data;
        default: ;  // index beyond the list: drop
      endcase
    end
  end

endmodule

// ----- rtl/sfr_parse.sv -----
// Frame parser state machine: takes one byte per beat, forms zero or one result.
// Depends on sfr_pkg and the assertion macros header.
`include "serial_frame_receiver_top_macros.svh"
module sfr_parse import sfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase, phase_next;
  logic [7:0]  length_low_held, length_low_held_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] frame_topic, frame_topic_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [7:0]  running_sum, running_sum_next;

  logic [7:0]  len_csum;
  logic [7:0]  data_csum;
  logic [15:0] seen_inc;
  logic [7:0]  sum_inc;

  assign len_csum  = ~(frame_length[15:8] + frame_length[7:0]);
  assign data_csum = ~running_sum;
  assign seen_inc  = bytes_seen + 16'd1;
  assign sum_inc   = running_sum + rx_byte;

  always_comb begin
    phase_next           = phase;
    length_low_held_next = length_low_held;
    frame_length_next    = frame_length;
    frame_topic_next     = frame_topic;
    bytes_seen_next      = bytes_seen;
    running_sum_next     = running_sum;
    res_valid            = 1'b0;
    res.kind             = KIND_PAYLOAD;
    res.msg_topic        = 16'd0;
    res.payload_byte     = 8'd0;
    res.byte_index       = 16'd0;
    res.payload_length   = frame_length;
    case (phase)
      PH_VERSION: begin
        if (rx_byte == cfg.version_byte) begin
          phase_next = PH_LEN_LO;
        end else if (rx_byte == cfg.sync_byte) begin
          phase_next = PH_VERSION;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_LEN_LO: begin
        length_low_held_next = rx_byte;
        phase_next           = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_length_next = {rx_byte, length_low_held};
        frame_topic_next  = 16'd0;
        phase_next        = PH_LEN_CSUM;
      end
      PH_LEN_CSUM: begin
        phase_next = PH_HUNT;
        if (rx_byte != len_csum) begin
          res_valid = 1'b1;
          res.kind  = KIND_LEN_BAD;
        end else if (frame_length > cfg.max_payload_length) begin
          res_valid = 1'b1;
          res.kind  = KIND_TOO_LONG;
        end else begin
          phase_next = PH_TOPIC_LO;
        end
      end
      PH_TOPIC_LO: begin
        frame_topic_next = {8'd0, rx_byte};
        running_sum_next = rx_byte;
        phase_next       = PH_TOPIC_HI;
      end
      PH_TOPIC_HI: begin
        frame_topic_next = {rx_byte, frame_topic[7:0]};
        running_sum_next = sum_inc;
        bytes_seen_next  = 16'd0;
        phase_next       = (frame_length == 16'd0) ? PH_DATA_CSUM : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        res_valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.msg_topic    = frame_topic;
        res.payload_byte = rx_byte;
        res.byte_index   = bytes_seen;
        running_sum_next = sum_inc;
        bytes_seen_next  = seen_inc;
        if (seen_inc >= frame_length) begin
          phase_next = PH_DATA_CSUM;
        end
      end
      PH_DATA_CSUM: begin
        res_valid     = 1'b1;
        res.kind      = (rx_byte == data_csum) ? KIND_GOOD : KIND_DATA_BAD;
        res.msg_topic = frame_topic;
        phase_next    = PH_HUNT;
      end
      default: begin
        // hunt, and any stray code
        phase_next = (rx_byte == cfg.sync_byte) ? PH_VERSION : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      length_low_held <= 8'd0;
      frame_length    <= 16'd0;
      frame_topic     <= 16'd0;
      bytes_seen      <= 16'd0;
      running_sum     <= 8'd0;
    end else if (accept) begin
      phase           <= phase_next;
      length_low_held <= length_low_held_next;
      frame_length    <= frame_length_next;
      frame_topic     <= frame_topic_next;
      bytes_seen      <= bytes_seen_next;
      running_sum     <= running_sum_next;
    end
  end

  `SFR_ASSERT(a_payload_nonempty, clk, rst, phase == PH_PAYLOAD |-> frame_length != 16'd0, "payload phase with zero length")
  `SFR_ASSERT(a_index_in_range, clk, rst, phase == PH_PAYLOAD |-> bytes_seen < frame_length, "payload index beyond declared length")
  `SFR_ASSERT(a_csum_ends_frame, clk, rst, accept && phase == PH_DATA_CSUM |=> phase == PH_HUNT, "no return to hunt after data checksum")

endmodule

// ----- rtl/sfr_out.sv -----
// Result register with one skid entry between the parser and the output channel.
// Depends on sfr_pkg and the assertion macros header.
`include "serial_frame_receiver_top_macros.svh"
module sfr_out import sfr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      // hold the head beat, park a new one in the skid entry
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (push) begin
        skid_data <= push_data;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (push) begin
      out_data <= push_data;
    end
  end

  `SFR_ASSERT(a_no_push_when_full, clk, rst, push |-> !skid_valid, "beat pushed into a full skid entry")
  `SFR_ASSERT(a_skid_behind_head, clk, rst, skid_valid |-> out_valid, "skid entry holds a beat with no head beat")
  `SFR_ASSERT(a_skid_drains, clk, rst, skid_valid && !out_stall |=> !skid_valid, "skid entry did not drain")

endmodule

// ----- test/sfr_result_check_pkg.sv -----
// Result checker for the serial frame receiver testbench: tracks the frame parse
// byte by byte and holds the results each accepted byte should produce.
// Depends on sfr_pkg for the phase and result types, register indexes and reset values.
package sfr_result_check_pkg;
  import sfr_pkg::*;

  class frame_result_checker;
    logic [7:0]  sync_byte;
    logic [7:0]  version_byte;
    logic [15:0] max_len;

    phase_t      phase;
    logic [7:0]  len_lo;
    logic [15:0] frame_len;
    logic [15:0] frame_topic;
    logic [15:0] bytes_seen;
    logic [7:0]  running_sum;

    result_t     results_due[$];
    int          errors;

    function new();
      sync_byte    = SYNC_RESET;
      version_byte = VERSION_RESET;
      max_len      = MAX_LEN_RESET;
      phase        = PH_HUNT;
      len_lo       = '0;
      frame_len    = '0;
      frame_topic  = '0;
      bytes_seen   = '0;
      running_sum  = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
      case (idx)
        CFG_SYNC:    sync_byte = data[7:0];
        CFG_VERSION: version_byte = data[7:0];
        CFG_MAX_LEN: max_len = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function void queue_result(logic [2:0] kind, logic [15:0] topic, logic [7:0] pb,
                               logic [15:0] idx);
      result_t r;
      r.kind           = kind;
      r.msg_topic      = topic;
      r.payload_byte   = pb;
      r.byte_index     = idx;
      r.payload_length = frame_len;
      results_due.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b);
      logic [7:0] want;
      case (phase)
        PH_VERSION: begin
          // version test first, so equal sync and version bytes still open a frame
          if (b == version_byte) phase = PH_LEN_LO;
          else if (b == sync_byte) phase = PH_VERSION;
          else phase = PH_HUNT;
        end
        PH_LEN_LO: begin
          len_lo = b;
          phase  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          frame_len   = {b, len_lo};
          frame_topic = '0;
          phase       = PH_LEN_CSUM;
        end
        PH_LEN_CSUM: begin
          want  = 8'hFF - (frame_len[15:8] + frame_len[7:0]);
          phase = PH_HUNT;
          if (b != want) queue_result(KIND_LEN_BAD, '0, '0, '0);
          else if (frame_len > max_len) queue_result(KIND_TOO_LONG, '0, '0, '0);
          else phase = PH_TOPIC_LO;
        end
        PH_TOPIC_LO: begin
          frame_topic = {8'h00, b};
          running_sum = b;
          phase       = PH_TOPIC_HI;
        end
        PH_TOPIC_HI: begin
          frame_topic[15:8] = b;
          running_sum       = running_sum + b;
          bytes_seen        = '0;
          phase             = (frame_len == 0) ? PH_DATA_CSUM : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          queue_result(KIND_PAYLOAD, frame_topic, b, bytes_seen);
          running_sum = running_sum + b;
          bytes_seen  = bytes_seen + 16'd1;
          if (bytes_seen >= frame_len) phase = PH_DATA_CSUM;
        end
        PH_DATA_CSUM: begin
          want  = 8'hFF - running_sum;
          phase = PH_HUNT;
          queue_result((b == want) ? KIND_GOOD : KIND_DATA_BAD, frame_topic, '0, '0);
        end
        default: begin
          phase = (b == sync_byte) ? PH_VERSION : PH_HUNT;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (results_due.size() == 0) begin
        $error("result beat with nothing expected: kind %0d topic 0x%0h",
               got.kind, got.msg_topic);
        errors++;
        return;
      end
      want = results_due.pop_front();
      compare_field("kind", 16'(want.kind), 16'(got.kind));
      compare_field("msg_topic", want.msg_topic, got.msg_topic);
      compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("payload_length", want.payload_length, got.payload_length);
    endfunction
  endclass

endpackage

// ----- test/tb_serial_frame_receiver_top.sv -----
// Top-level testbench of the serial frame receiver: builds frames, drives bytes with
// bursty valid and random output stall, and checks every result beat.
// Depends on sfr_pkg and sfr_result_check_pkg.
module tb_serial_frame_receiver_top import sfr_pkg::*, sfr_result_check_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  typedef enum int {FAULT_NONE, FAULT_LEN_CSUM, FAULT_DATA_CSUM, FAULT_CUT} fault_e;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_e;

  logic               clk;
  logic               rst = 1'b1;
  logic               rx_valid = 1'b0;
  logic               rx_stall;
  logic [7:0]         rx_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         kind;
  logic [15:0]        msg_topic;
  logic [7:0]         payload_byte;
  logic [15:0]        byte_index;
  logic [15:0]        payload_length;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  frame_result_checker frames = new();
  result_t     out_beat;
  logic [7:0]  line_bytes[$];
  logic [7:0]  cur_sync = SYNC_RESET;
  logic [7:0]  cur_version = VERSION_RESET;
  logic [15:0] cur_max = MAX_LEN_RESET;
  int          burst_left = 0;
  int          holds_asked = 0;
  int          holds_given = 0;
  int          hold_left = 0;
  int          mode_left = 0;
  stall_e      stall_mode = STALL_NONE;
  int          cycle_count = 0;

  serial_frame_receiver_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .rx_valid       (rx_valid),
    .rx_stall       (rx_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .msg_topic      (msg_topic),
    .payload_byte   (payload_byte),
    .byte_index     (byte_index),
    .payload_length (payload_length),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // check results before noting the byte of the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        out_beat.kind           = kind;
        out_beat.msg_topic      = msg_topic;
        out_beat.payload_byte   = payload_byte;
        out_beat.byte_index     = byte_index;
        out_beat.payload_length = payload_length;
        frames.check_result(out_beat);
      end
      if (rx_valid && !rx_stall) frames.take_byte(rx_byte);
      if (cfg_valid && cfg_ready) frames.write_reg(cfg_index, cfg_data);
    end
  end

  // output stall: random modes, plus long hold-offs on request
  initial begin
    forever begin
      @(negedge clk);
      if (holds_given != holds_asked) begin
        holds_given = holds_asked;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_e'($urandom_range(0, 3));
          mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ~out_stall;
        endcase
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_serial_frame_receiver_top: done, errors");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom_range(0, 8));
    if (r < 9) return 16'($urandom_range(9, 40));
    return 16'($urandom_range(41, 120));
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SYNC:    cur_sync = data[7:0];
      CFG_VERSION: cur_version = data[7:0];
      CFG_MAX_LEN: cur_max = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Queue one frame; a length above the current maximum stops after the length checksum.
  task automatic add_frame(input logic [15:0] len, input logic [15:0] topic,
                           input fault_e fault, input int nsync);
    logic [7:0] lcs;
    logic [7:0] dcs;
    logic [7:0] b;
    logic [7:0] sum;
    int         start;
    int         i;
    start = line_bytes.size();
    repeat (nsync) line_bytes.push_back(cur_sync);
    line_bytes.push_back(cur_version);
    line_bytes.push_back(len[7:0]);
    line_bytes.push_back(len[15:8]);
    lcs = 8'hFF - (len[15:8] + len[7:0]);
    if (fault == FAULT_LEN_CSUM) lcs = lcs ^ 8'($urandom_range(1, 255));
    line_bytes.push_back(lcs);
    if (fault != FAULT_LEN_CSUM && len <= cur_max) begin
      line_bytes.push_back(topic[7:0]);
      line_bytes.push_back(topic[15:8]);
      sum = topic[7:0] + topic[15:8];
      for (i = 0; i < len; i++) begin
        b = rand_byte();
        line_bytes.push_back(b);
        sum = sum + b;
      end
      dcs = 8'hFF - sum;
      if (fault == FAULT_DATA_CSUM) dcs = dcs ^ 8'($urandom_range(1, 255));
      line_bytes.push_back(dcs);
    end
    // drop the tail of a broken frame
    if (fault == FAULT_CUT && line_bytes.size() - start > 1) begin
      repeat ($urandom_range(1, line_bytes.size() - start - 1)) void'(line_bytes.pop_back());
    end
  endtask

  task automatic drive_line(input bit no_gaps);
    int gap;
    while (line_bytes.size() != 0) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (!no_gaps && gap != 0) begin
          @(negedge clk);
          rx_valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      @(negedge clk);
      rx_valid <= 1'b1;
      rx_byte  <= line_bytes.pop_front();
      @(posedge clk);
      while (rx_stall) @(posedge clk);
      burst_left--;
    end
    @(negedge clk);
    rx_valid <= 1'b0;
  endtask

  task automatic settle();
    while (frames.pending() != 0) @(negedge clk);
    // allow for bytes that produce no result still in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic random_traffic(input int n_bytes);
    int         pick;
    int         nsync;
    logic [15:0] len;
    fault_e     fault;
    bit         too_long;
    while (line_bytes.size() < n_bytes) begin
      pick     = $urandom_range(0, 99);
      nsync    = (cur_sync != cur_version && $urandom_range(0, 7) == 0)
                 ? $urandom_range(2, 3) : 1;
      len      = pick_len();
      fault    = FAULT_NONE;
      too_long = 1'b0;
      if (pick < 4) begin
        repeat ($urandom_range(1, 6)) line_bytes.push_back(rand_byte());
      end else begin
        if (pick < 12) fault = FAULT_LEN_CSUM;
        else if (pick < 19) begin
          if (cur_max != 16'hFFFF) too_long = 1'b1;
          else fault = FAULT_LEN_CSUM;
        end
        else if (pick < 26) fault = FAULT_DATA_CSUM;
        else if (pick < 30) fault = FAULT_CUT;
        if (too_long) begin
          len = ($urandom_range(0, 1) == 0) ? cur_max + 16'd1
                : 16'($urandom_range(int'(cur_max) + 1, 65535));
        end else if (len > cur_max) begin
          len = 16'($urandom_range(0, cur_max));
        end
        add_frame(len, {rand_byte(), rand_byte()}, fault, nsync);
      end
    end
    drive_line(1'b0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // register defaults: empty payload, repeated sync, each frame error, hunt recovery
    add_frame(16'd0, 16'h0000, FAULT_NONE, 1);
    add_frame(16'd3, 16'hFFFF, FAULT_NONE, 3);
    add_frame(16'hFFFF, 16'h0000, FAULT_LEN_CSUM, 1);
    add_frame(16'd513, 16'h1234, FAULT_NONE, 1);
    add_frame(16'd1, 16'h8001, FAULT_DATA_CSUM, 1);
    line_bytes.push_back(cur_sync);
    line_bytes.push_back(8'h00);
    add_frame(16'd2, 16'h00FF, FAULT_NONE, 1);
    drive_line(1'b0);
    settle();

    // zero markers, equal sync and version, nothing but empty payloads allowed
    write_reg(CFG_SYNC, {8'($urandom), 8'h00});
    write_reg(CFG_VERSION, 16'h0000);
    write_reg(CFG_MAX_LEN, 16'h0000);
    add_frame(16'd0, 16'hA55A, FAULT_NONE, 1);
    add_frame(16'd1, 16'h5AA5, FAULT_NONE, 1);
    random_traffic(350);
    settle();

    // widest length limit, plus a write to the unused index
    write_reg(CFG_SYNC, 16'h00A5);
    write_reg(CFG_VERSION, {8'($urandom), 8'h5A});
    write_reg(CFG_MAX_LEN, 16'hFFFF);
    write_reg(CFG_SPARE, 16'($urandom));
    add_frame(16'hFFFF, 16'hFFFF, FAULT_LEN_CSUM, 2);
    random_traffic(350);
    settle();

    // hold the output long enough to back up the input
    @(posedge clk);
    holds_asked++;
    add_frame(16'd80, {rand_byte(), rand_byte()}, FAULT_NONE, 1);
    drive_line(1'b1);
    settle();

    // small limit, boundary lengths
    write_reg(CFG_SYNC, 16'h00FF);
    write_reg(CFG_VERSION, 16'h00FF);
    write_reg(CFG_MAX_LEN, 16'd5);
    add_frame(16'd5, 16'hFFFF, FAULT_NONE, 1);
    add_frame(16'd6, 16'h0000, FAULT_NONE, 1);
    random_traffic(350);
    settle();

    write_reg(CFG_SYNC, 16'h007E);
    write_reg(CFG_VERSION, 16'h0001);
    write_reg(CFG_MAX_LEN, 16'd512);
    random_traffic(350);
    settle();
    repeat (8) @(posedge clk);

    if (frames.errors == 0) begin
      $display("tb_serial_frame_receiver_top: done, clean");
    end else begin
      $display("tb_serial_frame_receiver_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sfr_pkg.sv
rtl/sfr_cfg.sv
rtl/sfr_parse.sv
rtl/sfr_out.sv
rtl/serial_frame_receiver_top.sv
test/sfr_result_check_pkg.sv
test/tb_serial_frame_receiver_top.sv
